// File: design/assert_macros.svh
// Assertion macros for the joystick drive mixer.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define JDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define JDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/jdm_pkg.sv
// Shared types and constants for the joystick drive mixer.
// No dependencies.
package jdm_pkg;

    localparam logic [7:0] CMD_JOYSTICK = 8'h44;  // 'D'
    localparam logic [7:0] CMD_HEADING  = 8'h53;  // 'S'

    localparam int QUEUE_DEPTH = 2;
    localparam int DRIVE_W     = 10;
    localparam int PROD_W      = 18;
    localparam int SCALED_W    = 32;
    localparam int RECIP_SHIFT = 21;
    localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;
    // (2^21 - 1) / 127, applied to (m+1); exact for (m+1) < 2^21
    localparam logic [14:0] RECIP_127 = 15'd16513;

    typedef enum logic [2:0] {
        POS_CMD  = 3'b001,
        POS_ARG  = 3'b010,
        POS_LAST = 3'b100
    } frame_pos_t;

    typedef struct packed {
        logic       is_joy;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
    } frame_t;

endpackage

// File: design/joystick_drive_mixer.sv
// Joystick drive mixer: takes one received byte per cycle, groups bytes in
// frames of command, first argument, second argument, and for a 'D' or 'S'
// frame delivers one word of two signed motor drives, clamped to -256..256;
// other frames yield nothing. A byte is taken every cycle unless the front
// end stalls; the result of a frame passes through the frame queue and the
// drive pipeline (product, reciprocal multiply, output register).
// The front end stalls only when a 'D' or 'S' frame closes on a full queue.
// Depends on jdm_pkg, jdm_front, jdm_fifo, jdm_back and assert_macros.svh.
`include "assert_macros.svh"

module joystick_drive_mixer
    import jdm_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_first_drive,
    output logic signed [DRIVE_W-1:0] m_second_drive
);

    logic   q_push, q_full, q_pop, q_valid;
    frame_t push_item, pop_item;
    logic   first_ok, second_ok;

    jdm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    jdm_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    jdm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_drive  (m_first_drive),
        .m_second_drive (m_second_drive)
    );

    assign first_ok  = (m_first_drive >= -10'sd256) && (m_first_drive <= 10'sd256);
    assign second_ok = (m_second_drive >= -10'sd256) && (m_second_drive <= 10'sd256);

    `JDM_ASSERT_IMP(a_no_push_full, q_push, !q_full, "frame pushed into a full queue")
    `JDM_ASSERT_IMP(a_no_pop_empty, q_pop, q_valid, "frame popped from an empty queue")
    `JDM_ASSERT_IMP(a_stall_cause, !s_ready, q_full, "input stalled with queue space free")
    `JDM_ASSERT_IMP(a_drive_range, m_valid, first_ok && second_ok, "drive word out of range")

endmodule

// File: design/jdm_front.sv
// Front end: assembles three-byte frames and classifies the command.
// Depends on jdm_pkg.
module jdm_front
    import jdm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output frame_t     q_item
);

    frame_pos_t pos_reg, pos_next;
    logic [7:0] cmd_reg;
    logic [7:0] arg_reg;
    logic       known;
    logic       accept;

    assign known  = (cmd_reg == CMD_JOYSTICK) || (cmd_reg == CMD_HEADING);
    // only a closing frame with a known command needs queue space
    assign s_ready = !((pos_reg == POS_LAST) && known && q_full);
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (pos_reg == POS_LAST) && known;

    assign q_item.is_joy = (cmd_reg == CMD_JOYSTICK);
    assign q_item.arg_a  = arg_reg;
    assign q_item.arg_b  = s_rx_byte;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            unique case (pos_reg)
                POS_CMD:  pos_next = POS_ARG;
                POS_ARG:  pos_next = POS_LAST;
                POS_LAST: pos_next = POS_CMD;
                default:  pos_next = POS_ARG;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_CMD;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (pos_reg == POS_CMD)) begin
            cmd_reg <= s_rx_byte;
        end
        if (accept && (pos_reg == POS_ARG)) begin
            arg_reg <= s_rx_byte;
        end
    end

endmodule

// File: design/jdm_fifo.sv
// Short queue of decoded frames between front end and drive pipeline.
// Depends on jdm_pkg.
module jdm_fifo
    import jdm_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_item,
    output logic   full,
    input  logic   pop,
    output logic   pop_valid,
    output frame_t pop_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    frame_t          mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/jdm_back.sv
// Drive pipeline: mixing product, divide by constant, sign/swap and clamp.
// Depends on jdm_pkg.
module jdm_back
    import jdm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  frame_t                     q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DRIVE_W-1:0]  m_first_drive,
    output logic signed [DRIVE_W-1:0]  m_second_drive
);

    localparam logic signed [QUOT_W-1:0] LimitPos = QUOT_W'(256);
    localparam logic signed [QUOT_W-1:0] LimitNeg = -QUOT_W'(256);

    // ---- stage 1: speed term, steering factor, product ----
    logic signed [8:0]         a_off;
    logic signed [9:0]         p_joy, p_spd, p_sel;
    logic signed [8:0]         d_val, d_neg;
    logic [7:0]                d_mag;
    logic signed [9:0]         k_joy, k_spd, k_sel;
    logic [9:0]                l_twice;
    logic                      same_side;
    logic signed [19:0]        prod_full;

    logic                      s1_valid_reg, s1_valid_next;
    logic signed [PROD_W-1:0]  s1_prod_reg;
    logic signed [9:0]         s1_p_reg;
    logic                      s1_joy_reg, s1_neg_reg, s1_pf_first_reg;

    // ---- stage 2: magnitude times reciprocal, or shift by six for heading ----
    logic [PROD_W-2:0]         mag;
    logic [PROD_W-2:0]         mag_p1;
    logic [SCALED_W-1:0]       scaled;

    logic                      s2_valid_reg, s2_valid_next;
    logic [SCALED_W-1:0]       s2_scaled_reg;
    logic                      s2_sign_reg;
    logic signed [9:0]         s2_p_reg;
    logic                      s2_neg_reg, s2_pf_first_reg;

    // ---- stage 3: sign, swap, clamp ----
    logic signed [QUOT_W-1:0]  quot, pf, p_ext, first_raw, second_raw;
    logic                      m_valid_reg, m_valid_next;
    logic signed [DRIVE_W-1:0] first_reg, second_reg;

    logic out_ld, s2_free, s1_free;

    function automatic logic signed [DRIVE_W-1:0] clamp_drive(
        input logic signed [QUOT_W-1:0] v
    );
        logic signed [QUOT_W-1:0] c;
        begin
            c = v;
            if (v > LimitPos) c = LimitPos;
            if (v < LimitNeg) c = LimitNeg;
            clamp_drive = c[DRIVE_W-1:0];
        end
    endfunction

    assign out_ld  = !m_valid_reg || m_ready;
    assign s2_free = !s2_valid_reg || out_ld;
    assign s1_free = !s1_valid_reg || s2_free;
    assign q_pop   = q_valid && s1_free;

    always_comb begin
        a_off   = $signed({1'b0, q_item.arg_a}) - 9'sd127;
        p_joy   = {a_off, 1'b0};
        if ((p_joy > -10'sd30) && (p_joy < 10'sd30)) begin
            p_joy = '0;
        end
        d_val = 9'sd127 - $signed({1'b0, q_item.arg_b});
        d_neg = -d_val;
        d_mag = d_val[8] ? d_neg[7:0] : d_val[7:0];
        // inside the steering dead zone the factor is 127/127
        if (d_mag < 8'd15) begin
            k_joy = 10'sd127;
        end else begin
            k_joy = 10'sd127 - $signed({1'b0, d_mag, 1'b0});
        end
        same_side = (!p_joy[9] && !d_val[8]) || ((p_joy <= 0) && (d_val <= 0));

        p_spd   = (q_item.arg_a < 8'd50) ? 10'sd0 : $signed({2'b00, q_item.arg_a});
        l_twice = {3'b000, q_item.arg_b[5:0], 1'b0};
        // odd quadrants ramp down, even ones ramp up
        k_spd   = q_item.arg_b[6] ? (10'sd64 - $signed(l_twice))
                                  : ($signed(l_twice) - 10'sd64);

        p_sel     = q_item.is_joy ? p_joy : p_spd;
        k_sel     = q_item.is_joy ? k_joy : k_spd;
        prod_full = p_sel * k_sel;
    end

    always_comb begin
        mag    = s1_prod_reg[PROD_W-1] ? (PROD_W-1)'(-s1_prod_reg)
                                       : s1_prod_reg[PROD_W-2:0];
        mag_p1 = mag + (PROD_W-1)'(1);
        if (s1_joy_reg) begin
            scaled = SCALED_W'(mag_p1) * SCALED_W'(RECIP_127);
        end else begin
            scaled = {QUOT_W'(mag[PROD_W-2:6]), {RECIP_SHIFT{1'b0}}};
        end
    end

    always_comb begin
        quot       = $signed(s2_scaled_reg[SCALED_W-1:RECIP_SHIFT]);
        pf         = s2_sign_reg ? -quot : quot;
        p_ext      = QUOT_W'(s2_p_reg);
        first_raw  = s2_pf_first_reg ? pf : p_ext;
        second_raw = s2_pf_first_reg ? p_ext : pf;
        if (s2_neg_reg) begin
            first_raw  = -first_raw;
            second_raw = -second_raw;
        end
    end

    assign s1_valid_next = s1_free ? q_valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
    assign m_valid_next  = out_ld ? s2_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_prod_reg     <= prod_full[PROD_W-1:0];
            s1_p_reg        <= p_sel;
            s1_joy_reg      <= q_item.is_joy;
            s1_neg_reg      <= !q_item.is_joy && !q_item.arg_b[7];
            s1_pf_first_reg <= q_item.is_joy ? same_side : q_item.arg_b[6];
        end
        if (s1_valid_reg && s2_free) begin
            s2_scaled_reg   <= scaled;
            s2_sign_reg     <= s1_prod_reg[PROD_W-1];
            s2_p_reg        <= s1_p_reg;
            s2_neg_reg      <= s1_neg_reg;
            s2_pf_first_reg <= s1_pf_first_reg;
        end
        if (s2_valid_reg && out_ld) begin
            first_reg  <= clamp_drive(first_raw);
            second_reg <= clamp_drive(second_raw);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_drive  = first_reg;
    assign m_second_drive = second_reg;

endmodule

// File: test/tb.sv
// Testbench for joystick_drive_mixer: drives framed serial bytes and checks each
// drive word against an in-bench model of the joystick and heading mixing.
// Depends on jdm_pkg and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jdm_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_FRAMES = 600;
    localparam int DRIVE_MAX     = 256;
    localparam int DIRECTED_ROWS = 9;

    localparam logic [7:0] CMD_UNKNOWN = 8'h00;

    localparam logic [1:0] AT_CMD  = 2'd0;
    localparam logic [1:0] AT_ARG  = 2'd1;
    localparam logic [1:0] AT_LAST = 2'd2;

    typedef logic signed [DRIVE_W-1:0] drive_t;

    typedef struct {
        drive_t first;
        drive_t second;
    } drive_pair_t;

    typedef struct {
        logic [7:0] cmd;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
        bit         typed;
        bit         has_word;
        int         first;
        int         second;
    } frame_row_t;

    // typed rows: dead centre, full-scale steering both ways (the second one
    // saturates), full reverse, heading quadrant edge, unknown command
    frame_row_t directed [DIRECTED_ROWS] = '{
        '{CMD_JOYSTICK, 8'd127, 8'd127, 1'b1, 1'b1, 0, 0},
        '{CMD_JOYSTICK, 8'd255, 8'd0,   1'b1, 1'b1, -256, 256},
        '{CMD_JOYSTICK, 8'd255, 8'd255, 1'b1, 1'b1, 256, -256},
        '{CMD_JOYSTICK, 8'd0,   8'd127, 1'b1, 1'b1, -254, -254},
        '{CMD_HEADING,  8'd50,  8'd0,   1'b1, 1'b1, -50, 50},
        '{CMD_HEADING,  8'd255, 8'd100, 1'b0, 1'b0, 0, 0},
        '{CMD_HEADING,  8'd200, 8'd170, 1'b0, 1'b0, 0, 0},
        '{CMD_HEADING,  8'd255, 8'd255, 1'b0, 1'b0, 0, 0},
        '{CMD_UNKNOWN,  8'd255, 8'd0,   1'b1, 1'b0, 0, 0}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    drive_t     m_first_drive;
    drive_t     m_second_drive;

    drive_pair_t pending_drives [$];
    int          mismatches  = 0;
    int          words_seen  = 0;
    int          idle_cycles = 0;
    bit          send_calm   = 1'b0;
    bit          recv_calm   = 1'b0;

    // frame tracking mirrored from the accepted byte stream
    logic [1:0] frame_pos = AT_CMD;
    logic [7:0] held_cmd  = 8'h00;
    logic [7:0] held_arg  = 8'h00;

    joystick_drive_mixer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_drive  (m_first_drive),
        .m_second_drive (m_second_drive)
    );

    always #10 aclk = ~aclk;

    function automatic drive_t clamp_drive(input int v);
        if (v > DRIVE_MAX) return drive_t'(DRIVE_MAX);
        if (v < -DRIVE_MAX) return drive_t'(-DRIVE_MAX);
        return drive_t'(v);
    endfunction

    // returns 1 when the frame yields a drive word
    function automatic bit mix_frame(input logic [7:0] cmd, input logic [7:0] a,
                                     input logic [7:0] b, output drive_pair_t w);
        int p;
        int pf;
        int d;
        int ad;
        int h;
        w.first  = '0;
        w.second = '0;
        if (cmd == CMD_JOYSTICK) begin
            p = 2 * (int'(a) - 127);
            if (p > -30 && p < 30) p = 0;
            d  = 127 - int'(b);
            ad = (d < 0) ? -d : d;
            if (ad < 15) pf = p;
            else pf = (p * (127 - 2 * ad)) / 127;
            // inner wheel goes on the side the stick leans towards
            if ((p >= 0 && d >= 0) || (p <= 0 && d <= 0)) begin
                w.first  = clamp_drive(pf);
                w.second = clamp_drive(p);
            end else begin
                w.first  = clamp_drive(p);
                w.second = clamp_drive(pf);
            end
            return 1'b1;
        end
        if (cmd == CMD_HEADING) begin
            p = int'(a);
            if (p < 50) p = 0;
            h = int'(b);
            case (h / 64)
                0: begin
                    pf       = (p * (2 * h - 64)) / 64;
                    w.first  = clamp_drive(-p);
                    w.second = clamp_drive(-pf);
                end
                1: begin
                    pf       = (p * (64 - 2 * (h - 64))) / 64;
                    w.first  = clamp_drive(-pf);
                    w.second = clamp_drive(-p);
                end
                2: begin
                    pf       = (p * (2 * (h - 128) - 64)) / 64;
                    w.first  = clamp_drive(p);
                    w.second = clamp_drive(pf);
                end
                default: begin
                    pf       = (p * (64 - 2 * (h - 192))) / 64;
                    w.first  = clamp_drive(pf);
                    w.second = clamp_drive(p);
                end
            endcase
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // offer one byte, wait for it to be taken, then track the frame
    task automatic send_byte(input logic [7:0] b, input bit typed, input bit has_word,
                             input int first, input int second);
        int          gap;
        bit          has;
        drive_pair_t w;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        case (frame_pos)
            AT_ARG: begin
                held_arg  = b;
                frame_pos = AT_LAST;
            end
            AT_LAST: begin
                frame_pos = AT_CMD;
                has = mix_frame(held_cmd, held_arg, b, w);
                if (typed) begin
                    has      = has_word;
                    w.first  = drive_t'(first);
                    w.second = drive_t'(second);
                end
                if (has) pending_drives.push_back(w);
            end
            default: begin
                held_cmd  = b;
                frame_pos = AT_ARG;
            end
        endcase
    endtask

    initial begin : stimulus
        int         n;
        int         r;
        logic [7:0] cmd;
        logic [7:0] a;
        logic [7:0] b;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            send_byte(directed[i].cmd, 1'b0, 1'b0, 0, 0);
            send_byte(directed[i].arg_a, 1'b0, 1'b0, 0, 0);
            send_byte(directed[i].arg_b, directed[i].typed, directed[i].has_word,
                      directed[i].first, directed[i].second);
        end
        for (n = 0; n < RANDOM_FRAMES; n++) begin
            if (n % 20 == 0) send_calm = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 42) cmd = CMD_JOYSTICK;
            else if (r < 84) cmd = CMD_HEADING;
            else cmd = 8'($urandom_range(255));
            a = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            // lean on the dead-zone edges now and then
            if ($urandom_range(3) == 0) begin
                if (cmd == CMD_JOYSTICK) begin
                    a = 8'($urandom_range(147, 107));
                    b = 8'($urandom_range(149, 105));
                end else begin
                    a = 8'($urandom_range(60, 40));
                end
            end
            send_byte(cmd, 1'b0, 1'b0, 0, 0);
            send_byte(a, 1'b0, 1'b0, 0, 0);
            send_byte(b, 1'b0, 1'b0, 0, 0);
        end
        s_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        mismatches += pending_drives.size();
        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin : receiver
        int stall_left;
        int cycle_n;
        bit held_off;
        stall_left = 0;
        cycle_n    = 0;
        held_off   = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_n++;
            if (cycle_n % 100 == 0) recv_calm = ($urandom_range(3) == 0);
            // one long hold-off so the frame queue fills and the input stalls
            if (!held_off && words_seen >= 40) begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge aclk) begin
        drive_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: first %0d second %0d",
                             m_first_drive, m_second_drive);
            end else begin
                want = pending_drives.pop_front();
                if (want.first !== m_first_drive || want.second !== m_second_drive) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: expected %0d/%0d, got %0d/%0d",
                                 want.first, want.second, m_first_drive, m_second_drive);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: filelist.f
+incdir+design
design/jdm_pkg.sv
design/jdm_front.sv
design/jdm_fifo.sv
design/jdm_back.sv
design/joystick_drive_mixer.sv
test/tb.sv
